/* rtl/core/assert_macros.svh */
// Assertion macros shared by the stack machine RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/pcsm_pkg.sv */
// Shared types and constants for the p-code stack machine.
// No dependencies.
package pcsm_pkg;
   localparam int unsigned STACK_DEPTH_DEF = 1024;
   localparam int unsigned PC_W = 16;
   localparam int unsigned WORD_W = 32;

   localparam logic [3:0] OP_LIT = 4'd0;
   localparam logic [3:0] OP_OPR = 4'd1;
   localparam logic [3:0] OP_LOD = 4'd2;
   localparam logic [3:0] OP_STO = 4'd3;
   localparam logic [3:0] OP_CAL = 4'd4;
   localparam logic [3:0] OP_INT = 4'd5;
   localparam logic [3:0] OP_JMP = 4'd6;
   localparam logic [3:0] OP_JPC = 4'd7;
   localparam logic [3:0] OP_RED = 4'd8;
   localparam logic [3:0] OP_WRT = 4'd9;

   localparam logic [4:0] SUB_RET = 5'd0;
   localparam logic [4:0] SUB_NEG = 5'd1;
   localparam logic [4:0] SUB_ADD = 5'd2;
   localparam logic [4:0] SUB_SUB = 5'd3;
   localparam logic [4:0] SUB_MUL = 5'd4;
   localparam logic [4:0] SUB_DIV = 5'd5;
   localparam logic [4:0] SUB_ODD = 5'd6;
   localparam logic [4:0] SUB_EQL = 5'd8;
   localparam logic [4:0] SUB_NEQ = 5'd9;
   localparam logic [4:0] SUB_LSS = 5'd10;
   localparam logic [4:0] SUB_GEQ = 5'd11;
   localparam logic [4:0] SUB_GTR = 5'd12;
   localparam logic [4:0] SUB_LEQ = 5'd13;
   localparam logic [4:0] SUB_PRT = 5'd14;
   localparam logic [4:0] SUB_NL  = 5'd15;
   localparam logic [4:0] SUB_RD  = 5'd16;

   localparam logic [1:0] WK_NONE  = 2'd0;
   localparam logic [1:0] WK_SPACE = 2'd1;
   localparam logic [1:0] WK_NL    = 2'd2;
   localparam logic [1:0] WK_LINE  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OOR  = 2'd2;

   // Datapath operations driven by the controller.
   typedef enum logic [3:0] {
      DP_NOP     = 4'd0,
      DP_LATCH   = 4'd1,  // capture request fields
      DP_RD_ADDR = 4'd2,  // issue stack read at address register
      DP_RD_TAKE = 4'd3,  // take read data into a named register
      DP_WALK    = 4'd4,  // p <= read data, level count down
      DP_WR      = 4'd5,  // write stack memory
      DP_DIV     = 4'd6,  // one divider step
      DP_FINISH  = 4'd7   // commit registers and result
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      logic [1:0]  sel;   // address or target selector
   } dp_cmd_type;

   typedef struct packed {
      logic       walk_done;
      logic       div_done;
      logic       needs_div;
   } dp_stat_type;

   // Address selectors for reads.
   localparam logic [1:0] AS_P1  = 2'd0; // p + 1 during walk
   localparam logic [1:0] AS_T1  = 2'd1; // top - 1, also base for return
   localparam logic [1:0] AS_T2  = 2'd2; // top - 2, also base + 2
   localparam logic [1:0] AS_IDX = 2'd3; // p + operand
endpackage

/* rtl/core/pcsm_top_unused.sv */
// Top level of the p-code stack machine step block: controller plus datapath.
// Depends on pcsm_pkg, pcsm_ctrl, pcsm_datapath.
//
// Channel  | handshake          | fields
// req      | req_valid/ready    | opcode level_diff operand read_value (in)
// rsp      | rsp_valid/ready    | next_pc halted write_kind write_value status (out)
//
// A request is accepted only from idle; its result is registered after the
// static-link walk, the operand reads, a divide if needed and the stack writes.
// A divide runs on a one-bit-per-cycle divider; the stack has a single port.
// Requests are handled one at a time and never overlap.
// After reset a clearing pass zeroes the stack, and no request is taken until it
// ends. The result register holds until taken, and the next request is
// accepted no sooner than the edge after that.
module pcode_stack_machine_step
   import pcsm_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_opcode,
   input  logic [2:0]         req_level_diff,
   input  logic signed [31:0] req_operand,
   input  logic signed [31:0] req_read_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_next_pc,
   output logic               rsp_halted,
   output logic [1:0]         rsp_write_kind,
   output logic signed [31:0] rsp_write_value,
   output logic [1:0]         rsp_status
);
   // The controller owns the handshakes and sequences memory reads, the
   // static-link walk, the divide and the writes; the datapath holds the
   // architectural registers and reports walk and divide completion.
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        clear_en;
   logic [$clog2(STACK_DEPTH)-1:0] clear_addr;

   pcsm_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd, .clear_en, .clear_addr);

   pcsm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .clear_en, .clear_addr, .cmd,
      .req_opcode, .req_level_diff, .req_operand, .req_read_value, .stat,
      .rsp_next_pc, .rsp_halted, .rsp_write_kind, .rsp_write_value, .rsp_status);
endmodule

/* rtl/core/pcsm_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module pcsm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/core/pcsm_datapath.sv */
// Datapath of the stack machine: architectural registers, operand staging,
// stack memory, serial divider. Depends on pcsm_pkg and pcsm_ram.
module pcsm_datapath
   import pcsm_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear_en,
   input  logic [$clog2(STACK_DEPTH)-1:0] clear_addr,
   input  dp_cmd_type         cmd,
   input  logic [3:0]         req_opcode,
   input  logic [2:0]         req_level_diff,
   input  logic signed [31:0] req_operand,
   input  logic signed [31:0] req_read_value,
   output dp_stat_type        stat,
   output logic [15:0]        rsp_next_pc,
   output logic               rsp_halted,
   output logic [1:0]         rsp_write_kind,
   output logic signed [31:0] rsp_write_value,
   output logic [1:0]         rsp_status
);
   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned TW = AW + 1;
   localparam logic signed [33:0] DEPTH_S = 34'(STACK_DEPTH);

   logic [TW-1:0] top_ff;
   logic [AW-1:0] base_ff;
   logic [15:0]   pc_ff;
   logic [3:0]    op_ff;
   logic [2:0]    lev_ff;
   logic [31:0]   arg_ff, rv_ff;
   logic signed [33:0] p_ff;      // walked base
   logic [31:0]   x_ff, y_ff, z_ff; // below top, top, word at p + operand
   logic          walk_bad_ff;

   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_wdata, ram_rdata;
   logic          ram_we;

   // Divider state.
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [5:0]  dcnt_ff;

   // Decode and ALU results; is_bin is shared by the write stage and the commit.
   logic        is_bin;
   logic [31:0] alu_res;
   logic        lt, eq;

   pcsm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata));

   logic signed [33:0] t_s, b_s, a_s, idx_s;
   assign t_s = 34'(top_ff);
   assign b_s = 34'(base_ff);
   assign a_s = 34'(signed'(arg_ff));
   assign idx_s = p_ff + a_s;

   function automatic logic inr(input logic signed [33:0] v);
      return (v >= 0) && (v < DEPTH_S);
   endfunction

   logic [4:0] sub;
   logic       sub_ok;
   assign sub_ok = (arg_ff <= 32'd16);
   assign sub = arg_ff[4:0];

   // Read address selection. For a return, x gets the word at base + 2 (the
   // return pc) and y the word at base (the caller's base).
   logic signed [33:0] rd_a;
   always_comb begin
      case (cmd.sel)
         AS_P1:  rd_a = p_ff + 34'sd1;
         AS_T1:  rd_a = (op_ff == OP_OPR && sub_ok && sub == SUB_RET) ? b_s : t_s - 34'sd1;
         AS_T2:  rd_a = (op_ff == OP_OPR && sub_ok && sub == SUB_RET) ? b_s + 34'sd2
                                                                     : t_s - 34'sd2;
         default: rd_a = idx_s;
      endcase
   end

   // Write stage: sel picks which of up to three writes.
   logic [AW-1:0] wr_a;
   logic [31:0]   wr_d;
   logic          wr_go;
   logic          bad;
   always_comb begin
      wr_a  = top_ff[AW-1:0];
      wr_d  = arg_ff;
      wr_go = !bad;
      unique case (op_ff)
         OP_LIT: begin wr_a = top_ff[AW-1:0]; wr_d = arg_ff; end
         OP_OPR: begin
            if (sub == SUB_RD) begin
               wr_a = top_ff[AW-1:0]; wr_d = rv_ff;
            end else if (sub == SUB_NEG || sub == SUB_ODD) begin
               wr_a = AW'(t_s - 34'sd1);
               wr_d = (sub == SUB_NEG) ? 32'd0 - y_ff
                    : ((y_ff[31] && y_ff[0]) ? 32'hFFFF_FFFF : {31'd0, y_ff[0]});
            end else begin
               wr_a = AW'(t_s - 34'sd2); wr_d = alu_res;
            end
            wr_go = !bad && sub_ok && (sub == SUB_RD || sub == SUB_NEG || sub == SUB_ODD ||
                    is_bin);
         end
         OP_LOD: begin wr_a = top_ff[AW-1:0]; wr_d = z_ff; end
         OP_STO: begin wr_a = AW'(idx_s); wr_d = y_ff; end
         OP_CAL: begin
            case (cmd.sel)
               2'd0:    begin wr_a = top_ff[AW-1:0]; wr_d = 32'(base_ff); end
               2'd1:    begin wr_a = AW'(t_s + 34'sd1); wr_d = p_ff[31:0]; end
               default: begin wr_a = AW'(t_s + 34'sd2); wr_d = {16'd0, pc_ff + 16'd1}; end
            endcase
         end
         OP_RED: begin
            wr_a = (cmd.sel == 2'd0) ? top_ff[AW-1:0] : AW'(idx_s);
            wr_d = rv_ff;
         end
         default: wr_go = 1'b0;
      endcase
   end

   assign ram_we    = clear_en || (cmd.op == DP_WR && wr_go);
   assign ram_addr  = clear_en ? clear_addr : (cmd.op == DP_WR ? wr_a : AW'(rd_a));
   assign ram_wdata = clear_en ? '0 : wr_d;

   // Classify and compute the bad condition from staged values.
   assign is_bin = sub_ok && ((sub >= SUB_ADD && sub <= SUB_DIV) ||
                              (sub >= SUB_EQL && sub <= SUB_LEQ));
   always_comb begin
      bad = 1'b0;
      unique case (op_ff) inside
         OP_LIT: bad = !inr(t_s);
         OP_OPR: begin
            if (sub_ok && sub == SUB_RET)
               bad = !inr(b_s + 34'sd2) || !inr(34'(signed'(y_ff)));
            else if (sub_ok && (sub == SUB_NEG || sub == SUB_ODD || sub == SUB_PRT))
               bad = !inr(t_s - 34'sd1);
            else if (is_bin) bad = !inr(t_s - 34'sd2);
            else if (sub_ok && sub == SUB_RD) bad = !inr(t_s);
         end
         OP_LOD, OP_RED: bad = !inr(t_s) || walk_bad_ff || !inr(idx_s);
         OP_STO: bad = !inr(t_s - 34'sd1) || walk_bad_ff || !inr(idx_s);
         OP_CAL: bad = !inr(t_s + 34'sd2) || walk_bad_ff;
         OP_INT: bad = (t_s + a_s < 0) || (t_s + a_s > DEPTH_S);
         OP_JPC, OP_WRT: bad = !inr(t_s - 34'sd1);
         default: bad = 1'b0;
      endcase
   end

   // ALU for two-operand subcodes; x below top, y top.
   assign eq = (x_ff == y_ff);
   assign lt = signed'(x_ff) < signed'(y_ff);
   always_comb begin
      case (sub)
         SUB_ADD: alu_res = x_ff + y_ff;
         SUB_SUB: alu_res = x_ff - y_ff;
         SUB_MUL: alu_res = x_ff * y_ff;
         SUB_DIV: alu_res = (y_ff == 32'd0) ? 32'd0
                           : ((x_ff[31] ^ y_ff[31]) ? 32'd0 - dq_ff : dq_ff);
         SUB_EQL: alu_res = {31'd0, eq};
         SUB_NEQ: alu_res = {31'd0, !eq};
         SUB_LSS: alu_res = {31'd0, lt};
         SUB_GEQ: alu_res = {31'd0, !lt};
         SUB_GTR: alu_res = {31'd0, !lt && !eq};
         default: alu_res = {31'd0, lt || eq};
      endcase
   end

   assign stat.walk_done = (lev_ff == 3'd0) || walk_bad_ff;
   assign stat.div_done  = (dcnt_ff == 6'd0);
   assign stat.needs_div = (op_ff == OP_OPR) && sub_ok && (sub == SUB_DIV) && !bad;

   logic [32:0] dtrial;
   assign dtrial = {dr_ff, dd_ff[31]} - {1'b0, (y_ff[31] ? 32'd0 - y_ff : y_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0; base_ff <= '0; pc_ff <= '0; dcnt_ff <= '0; op_ff <= OP_LIT;
      end else begin
         unique case (cmd.op)
            DP_LATCH: begin
               op_ff <= req_opcode; lev_ff <= req_level_diff;
               arg_ff <= req_operand; rv_ff <= req_read_value;
               p_ff <= 34'(base_ff); walk_bad_ff <= 1'b0;
               dcnt_ff <= '0;
            end
            DP_RD_TAKE: begin
               case (cmd.sel)
                  2'd0: x_ff <= ram_rdata;
                  2'd1: y_ff <= ram_rdata;
                  default: z_ff <= ram_rdata;
               endcase
               if (cmd.sel == 2'd1 && (op_ff == OP_OPR) && sub == SUB_DIV) begin
                  dd_ff <= x_ff[31] ? 32'd0 - x_ff : x_ff;
                  dr_ff <= '0; dq_ff <= '0; dcnt_ff <= 6'd32;
               end
            end
            DP_WALK: begin
               if (lev_ff != 3'd0 && !walk_bad_ff) begin
                  if (!inr(p_ff + 34'sd1)) walk_bad_ff <= 1'b1;
                  else begin
                     p_ff <= 34'(signed'(ram_rdata));
                     lev_ff <= lev_ff - 3'd1;
                  end
               end
            end
            DP_DIV: begin
               if (dcnt_ff != 6'd0) begin
                  dd_ff <= {dd_ff[30:0], 1'b0};
                  if (!dtrial[32]) begin
                     dr_ff <= dtrial[31:0]; dq_ff <= {dq_ff[30:0], 1'b1};
                  end else begin
                     dr_ff <= {dr_ff[30:0], dd_ff[31]}; dq_ff <= {dq_ff[30:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff - 6'd1;
               end
            end
            DP_FINISH: begin
               rsp_status <= bad ? ST_OOR
                  : ((op_ff == OP_OPR && sub_ok && sub == SUB_DIV && y_ff == 32'd0)
                     ? ST_DIV0 : ST_OK);
               rsp_write_kind <= WK_NONE;
               rsp_write_value <= '0;
               if (bad) begin
                  pc_ff <= pc_ff + 16'd1;
               end else begin
                  pc_ff <= pc_ff + 16'd1;
                  unique case (op_ff) inside
                     OP_LIT, OP_LOD, OP_RED: top_ff <= top_ff + TW'(1);
                     OP_OPR: begin
                        if (sub_ok && sub == SUB_RET) begin
                           top_ff <= TW'(base_ff); base_ff <= AW'(y_ff);
                           pc_ff <= x_ff[15:0];
                        end else if (is_bin) top_ff <= top_ff - TW'(1);
                        else if (sub_ok && sub == SUB_RD) top_ff <= top_ff + TW'(1);
                        else if (sub_ok && sub == SUB_PRT) begin
                           rsp_write_kind <= WK_SPACE; rsp_write_value <= y_ff;
                        end else if (sub_ok && sub == SUB_NL) rsp_write_kind <= WK_NL;
                     end
                     OP_CAL: begin base_ff <= top_ff[AW-1:0]; pc_ff <= arg_ff[15:0]; end
                     OP_INT: top_ff <= TW'(t_s + a_s);
                     OP_JMP: pc_ff <= arg_ff[15:0];
                     OP_JPC: if (y_ff == 32'd0) pc_ff <= arg_ff[15:0];
                     OP_WRT: begin rsp_write_kind <= WK_LINE; rsp_write_value <= y_ff; end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_next_pc = pc_ff;
   assign rsp_halted  = (pc_ff == 16'd0);
endmodule

/* rtl/core/pcsm_ctrl.sv */
// Controller of the stack machine: sequences reads, walk, divide, writes.
// Depends on pcsm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcsm_ctrl
   import pcsm_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        clear_en,
   output logic [$clog2(STACK_DEPTH)-1:0] clear_addr
);
   localparam int unsigned AW = $clog2(STACK_DEPTH);

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_WALKA = 11'b00000000100, // issue p+1 read
      S_WALKB = 11'b00000001000, // read data arrives, step
      S_RDA   = 11'b00000010000, // issue reads: T2 then T1 then IDX
      S_RDB   = 11'b00000100000,
      S_RDC   = 11'b00001000000,
      S_RDD   = 11'b00010000000,
      S_DIV   = 11'b00100000000,
      S_WR    = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] wcnt_ff, wcnt_in;
   logic [AW-1:0] clr_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign clear_en   = (state_ff == S_CLEAR);
   assign clear_addr = clr_ff;
   assign req_ready  = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      wcnt_in = wcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '{op: DP_NOP, sel: AS_P1};
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(STACK_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: if (req_valid && req_ready) begin
            cmd.op = DP_LATCH; state_in = S_WALKA;
         end
         S_WALKA: begin
            cmd = '{op: DP_RD_ADDR, sel: AS_P1};
            state_in = stat.walk_done ? S_RDA : S_WALKB;
         end
         S_WALKB: begin cmd = '{op: DP_WALK, sel: AS_P1}; state_in = S_WALKA; end
         S_RDA: begin cmd = '{op: DP_RD_ADDR, sel: AS_T2}; state_in = S_RDB; end
         S_RDB: begin cmd = '{op: DP_RD_TAKE, sel: 2'd0}; state_in = S_RDC; end
         S_RDC: begin
            // Address T1 was set combinationally; take it next cycle.
            cmd = '{op: DP_RD_ADDR, sel: AS_T1}; state_in = S_RDD;
         end
         S_RDD: begin cmd = '{op: DP_RD_TAKE, sel: 2'd1}; state_in = S_DIV; wcnt_in = 2'd0; end
         S_DIV: begin
            cmd = '{op: DP_DIV, sel: AS_IDX};
            // The read of p+operand is issued here each cycle.
            if (stat.div_done) state_in = S_WR;
         end
         S_WR: begin
            if (wcnt_ff == 2'd0) begin
               cmd = '{op: DP_RD_TAKE, sel: 2'd2};
               wcnt_in = 2'd1;
            end else begin
               cmd = '{op: DP_WR, sel: 2'(wcnt_ff - 2'd1)};
               wcnt_in = wcnt_ff + 2'd1;
               if (wcnt_ff == 2'd3) state_in = S_OUT;
            end
         end
         S_OUT: begin
            cmd.op = DP_FINISH; rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; wcnt_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; wcnt_ff <= wcnt_in; rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + AW'(1);
      end
   end

   `ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE,
      "ready outside idle")
   `ASSERT_NEXT(a_out_valid, clock, reset, state_ff == S_OUT, rsp_valid,
      "result not raised after finish")
   `ASSERT_IMPLY(a_no_req_clear, clock, reset, clear_en, !req_ready,
      "request taken during clear")
endmodule

/* bench/tb.sv */
// Self-checking bench for the p-code stack machine step block.
// It predicts each result from its own copy of the stack state.
// Depends on pcsm_pkg and pcode_stack_machine_step.
`timescale 1ns / 100ps

module tb;
   import pcsm_pkg::*;

   localparam int DEPTH = 1024;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [2:0]  level_diff;
      logic [31:0] operand;
      logic [31:0] read_value;
   } instr_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        halted;
      logic [1:0]  write_kind;
      logic [31:0] write_value;
      logic [1:0]  status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_opcode = '0;
   logic [2:0] req_level_diff = '0;
   logic signed [31:0] req_operand = '0;
   logic signed [31:0] req_read_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_next_pc;
   logic rsp_halted;
   logic [1:0] rsp_write_kind;
   logic signed [31:0] rsp_write_value;
   logic [1:0] rsp_status;

   pcode_stack_machine_step DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the machine state.
   logic [31:0] mem_words [DEPTH];
   longint top_idx, base_idx;
   logic [15:0] pc_reg;

   instr_type pending_instrs[$];
   outcome_type expected_outcomes[$];
   int errors = 0;
   int sent_count = 0, checked_count = 0;
   int send_idle_pct = 38, recv_idle_pct = 50;
   bit hold_receiver = 0;
   int hold_left = 0;

   function automatic longint sext(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   function automatic bit in_stack(longint i);
      return i >= 0 && i < DEPTH;
   endfunction

   // Static chain walk; returns 0 when a link address leaves the stack.
   function automatic bit follow_links(int lev, output longint p);
      p = base_idx;
      repeat (lev) begin
         if (!in_stack(p + 1)) return 0;
         p = sext(mem_words[p + 1]);
      end
      return 1;
   endfunction

   function automatic outcome_type execute_instr(instr_type it);
      outcome_type o;
      longint t, b, a, p, idx, nb, xs, ys;
      logic [31:0] x, y, r;
      logic [15:0] np;
      logic [1:0] kind, st;
      logic [31:0] wv;
      bit bad;
      t = top_idx; b = base_idx; a = sext(it.operand);
      np = pc_reg + 16'd1; kind = WK_NONE; wv = '0; st = ST_OK; bad = 0; p = 0;
      case (it.opcode)
         OP_LIT: begin
            if (!in_stack(t)) bad = 1;
            else begin mem_words[t] = it.operand; top_idx = t + 1; end
         end
         OP_OPR: begin
            if (a == SUB_RET) begin
               if (!in_stack(b + 2)) bad = 1;
               else begin
                  nb = sext(mem_words[b]);
                  if (!in_stack(nb)) bad = 1;
                  else begin
                     np = mem_words[b + 2][15:0];
                     top_idx = b; base_idx = nb;
                  end
               end
            end else if (a == SUB_NEG || a == SUB_ODD || a == SUB_PRT) begin
               if (!in_stack(t - 1)) bad = 1;
               else if (a == SUB_NEG) mem_words[t - 1] = -mem_words[t - 1];
               else if (a == SUB_ODD)
                  mem_words[t - 1] = 32'(sext(mem_words[t - 1]) % 2);
               else begin kind = WK_SPACE; wv = mem_words[t - 1]; end
            end else if ((a >= SUB_ADD && a <= SUB_DIV) || (a >= SUB_EQL && a <= SUB_LEQ)) begin
               if (!in_stack(t - 2)) bad = 1;
               else begin
                  x = mem_words[t - 2]; y = mem_words[t - 1];
                  xs = sext(x); ys = sext(y);
                  case (a)
                     SUB_ADD: r = x + y;
                     SUB_SUB: r = x - y;
                     SUB_MUL: r = x * y;
                     SUB_DIV: if (y == 0) begin r = 0; st = ST_DIV0; end
                              else r = 32'(xs / ys);
                     SUB_EQL: r = {31'd0, x == y};
                     SUB_NEQ: r = {31'd0, x != y};
                     SUB_LSS: r = {31'd0, xs < ys};
                     SUB_GEQ: r = {31'd0, xs >= ys};
                     SUB_GTR: r = {31'd0, xs > ys};
                     default: r = {31'd0, xs <= ys};
                  endcase
                  mem_words[t - 2] = r; top_idx = t - 1;
               end
            end else if (a == SUB_NL) kind = WK_NL;
            else if (a == SUB_RD) begin
               if (!in_stack(t)) bad = 1;
               else begin mem_words[t] = it.read_value; top_idx = t + 1; end
            end
         end
         OP_LOD: begin
            if (!in_stack(t) || !follow_links(it.level_diff, p)) bad = 1;
            else begin
               idx = p + a;
               if (!in_stack(idx)) bad = 1;
               else begin mem_words[t] = mem_words[idx]; top_idx = t + 1; end
            end
         end
         OP_STO: begin
            if (!in_stack(t - 1) || !follow_links(it.level_diff, p)) bad = 1;
            else begin
               idx = p + a;
               if (!in_stack(idx)) bad = 1;
               else mem_words[idx] = mem_words[t - 1];
            end
         end
         OP_CAL: begin
            if (!in_stack(t + 2) || !follow_links(it.level_diff, p)) bad = 1;
            else begin
               mem_words[t] = 32'(b); mem_words[t + 1] = 32'(p);
               mem_words[t + 2] = {16'd0, np};
               base_idx = t; np = it.operand[15:0];
            end
         end
         OP_INT: begin
            idx = t + a;
            if (idx < 0 || idx > DEPTH) bad = 1;
            else top_idx = idx;
         end
         OP_JMP: np = it.operand[15:0];
         OP_JPC: begin
            if (!in_stack(t - 1)) bad = 1;
            else if (mem_words[t - 1] == 0) np = it.operand[15:0];
         end
         OP_RED: begin
            if (!in_stack(t) || !follow_links(it.level_diff, p)) bad = 1;
            else begin
               idx = p + a;
               if (!in_stack(idx)) bad = 1;
               else begin
                  mem_words[t] = it.read_value; mem_words[idx] = it.read_value;
                  top_idx = t + 1;
               end
            end
         end
         OP_WRT: begin
            if (!in_stack(t - 1)) bad = 1;
            else begin kind = WK_LINE; wv = mem_words[t - 1]; end
         end
         default: ;
      endcase
      if (bad) begin
         st = ST_OOR; kind = WK_NONE; wv = '0; np = pc_reg + 16'd1;
      end
      pc_reg = np;
      o.next_pc = np; o.halted = (np == 0); o.write_kind = kind;
      o.write_value = wv; o.status = st;
      return o;
   endfunction

   // Driver: offers the queued requests, prediction happens on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outcomes.push_back(execute_instr(
               instr_type'{req_opcode, req_level_diff, req_operand, req_read_value}));
            sent_count++;
         end
         if ((!req_valid || req_ready) && pending_instrs.size() > 0
             && $urandom_range(99) >= send_idle_pct) begin
            instr_type it;
            it = pending_instrs.pop_front();
            req_valid <= 1'b1;
            req_opcode <= it.opcode; req_level_diff <= it.level_diff;
            req_operand <= it.operand; req_read_value <= it.read_value;
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   // A hold request starts a long stretch without ready, counted here.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result pc=%0d", $time, rsp_next_pc);
               errors++;
            end else begin
               outcome_type e;
               e = expected_outcomes.pop_front();
               checked_count++;
               if (e.next_pc !== rsp_next_pc)
                  $display("%0t: next_pc expected %0d actual %0d", $time, e.next_pc,
                           rsp_next_pc);
               if (e.halted !== rsp_halted)
                  $display("%0t: halted expected %0d actual %0d", $time, e.halted, rsp_halted);
               if (e.write_kind !== rsp_write_kind)
                  $display("%0t: write_kind expected %0d actual %0d", $time, e.write_kind,
                           rsp_write_kind);
               if (e.write_value !== rsp_write_value)
                  $display("%0t: write_value expected %0d actual %0d", $time,
                           $signed(e.write_value), rsp_write_value);
               if (e.status !== rsp_status)
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               if (e !== {rsp_next_pc, rsp_halted, rsp_write_kind, rsp_write_value, rsp_status})
                  errors++;
            end
         end
         if (hold_receiver) hold_left <= HOLD_CYCLES;
         else if (hold_left > 0) hold_left <= hold_left - 1;
         rsp_ready <= !hold_receiver && (hold_left <= 1) &&
                      ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any handshake.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d quiet cycles, %0d results pending", quiet_cycles,
                  expected_outcomes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($urandom_range(40)) - 32'd20;
         3: return 32'(-1);
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_instr(logic [3:0] op, int lev, logic [31:0] opnd,
                                      logic [31:0] rv);
      pending_instrs.push_back(instr_type'{op, 3'(lev), opnd, rv});
   endfunction

   // Mostly small offsets so stack accesses hit valid slots; some wild values.
   function automatic void push_random_instr();
      logic [3:0] op;
      logic [31:0] opnd;
      int pick;
      pick = $urandom_range(99);
      op = (pick < 5) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      case (op) inside
         OP_OPR: opnd = ($urandom_range(9) == 0) ? rand_word() : 32'($urandom_range(17));
         OP_INT: opnd = ($urandom_range(9) == 0) ? rand_word()
                        : 32'($urandom_range(8)) - 32'd3;
         OP_LIT: opnd = rand_word();
         OP_JMP, OP_JPC, OP_CAL: opnd = $urandom;
         default: opnd = ($urandom_range(9) == 0) ? rand_word() : 32'($urandom_range(12));
      endcase
      push_instr(op, int'(($urandom_range(7) < 5) ? $urandom_range(2) : $urandom_range(7)),
                 opnd, rand_word());
   endfunction

   task automatic wait_drained();
      while (pending_instrs.size() > 0 || req_valid || expected_outcomes.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      foreach (mem_words[i]) mem_words[i] = '0;
      top_idx = 0; base_idx = 0; pc_reg = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow first, then every opcode and some corner cases.
      push_instr(OP_WRT, 0, 0, 0);
      push_instr(OP_OPR, 0, 32'(SUB_ADD), 0);
      push_instr(OP_INT, 0, 32'(-1), 0);
      push_instr(OP_INT, 0, 5, 0);
      push_instr(OP_LIT, 0, 32'h8000_0000, 0);
      push_instr(OP_LIT, 0, 32'(-1), 0);
      push_instr(OP_OPR, 0, 32'(SUB_DIV), 0);
      push_instr(OP_LIT, 0, 0, 0);
      push_instr(OP_OPR, 0, 32'(SUB_DIV), 0);
      push_instr(OP_JPC, 0, 32'h0001_1234, 0);
      push_instr(OP_OPR, 7, 32'(SUB_RD), 32'(-7));
      push_instr(OP_OPR, 0, 32'(SUB_ODD), 0);
      push_instr(OP_OPR, 0, 32'(SUB_PRT), 0);
      push_instr(OP_OPR, 0, 32'(SUB_NL), 0);
      push_instr(OP_OPR, 0, 7, 0);
      push_instr(OP_OPR, 0, 32'h7fff_ffff, 0);
      push_instr(OP_RED, 0, 2, 32'h7fff_ffff);
      push_instr(OP_LOD, 1, 1, 0);
      push_instr(OP_STO, 0, 32'h8000_0000, 0);
      push_instr(OP_CAL, 0, 32'hffff_0020, 0);
      push_instr(OP_LOD, 7, 0, 0);
      push_instr(OP_OPR, 0, 32'(SUB_RET), 0);
      push_instr(OP_INT, 0, 1019, 0);
      push_instr(OP_CAL, 0, 3, 0);
      push_instr(4'd15, 7, 32'hffff_ffff, 32'hffff_ffff);
      push_instr(OP_JMP, 0, 0, 0);
      wait_drained();

      // Receiver holds off while the sender keeps offering requests.
      send_idle_pct = 0;
      repeat (30) push_random_instr();
      hold_receiver <= 1'b1;
      @(posedge clock);
      hold_receiver <= 1'b0;
      wait_drained();

      send_idle_pct = 38; recv_idle_pct = 50;
      repeat (300) push_random_instr();
      wait_drained();
      send_idle_pct = 50; recv_idle_pct = 38;
      repeat (300) push_random_instr();
      wait_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (270) push_random_instr();
      wait_drained();

      repeat (50) @(posedge clock);
      $display("Ran %0d instructions, %0d results checked, across stalls and idle mixes.",
               sent_count, checked_count);
      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
